>>> sv/glt_pkg.sv
// Shared types and constants for the glyph text layout engine.
package glt_pkg;

    localparam int MODE_W    = 2;
    localparam int CODE_W    = 16;
    localparam int POS_W     = 16;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SRC_X_W   = 16;
    localparam int SRC_Y_W   = 20;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENTRY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BEGIN   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CHAR    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_COLUMNS = 2'd2;

    localparam logic [CFG_W-1:0] RST_TILE_WIDTH    = 8'd8;
    localparam logic [CFG_W-1:0] RST_TILE_HEIGHT   = 8'd8;
    localparam logic [CFG_W-1:0] RST_ATLAS_COLUMNS = 8'd16;

    // Character codes with special handling.
    localparam logic [CODE_W-1:0] CH_NUL     = 16'h0000;
    localparam logic [CODE_W-1:0] CH_TAB     = 16'h0009;
    localparam logic [CODE_W-1:0] CH_NEWLINE = 16'h000A;
    localparam logic [CODE_W-1:0] CH_SPACE   = 16'h0020;
    localparam logic [CODE_W-1:0] CH_NONE    = 16'hFFFF;

    // Lowercase ranges folded to uppercase.
    localparam logic [CODE_W-1:0] LATIN_LO    = 16'h0061;
    localparam logic [CODE_W-1:0] LATIN_HI    = 16'h007A;
    localparam logic [CODE_W-1:0] CYRIL_LO    = 16'h0430;
    localparam logic [CODE_W-1:0] CYRIL_HI    = 16'h044F;
    localparam logic [CODE_W-1:0] FOLD_OFFSET = 16'h0020;

    typedef struct packed {
        logic accept;
        logic clr_we;
        logic div_load;
        logic div_step;
        logic mul;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic glyph_item;
    } t_sts;

endpackage

>>> sv/glt_in_if.sv
// Input channel interface: one text or table item per word.
interface glt_in_if
    import glt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [CODE_W-1:0]        code_point;
    logic signed [POS_W-1:0]  start_x;
    logic signed [POS_W-1:0]  start_y;

    modport source (output valid, mode, code_point, start_x, start_y, input ready);
    modport sink   (input valid, mode, code_point, start_x, start_y, output ready);
endinterface

>>> sv/glt_out_if.sv
// Output channel interface: one tile copy command per word.
interface glt_out_if
    import glt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     draw;
    logic [SRC_X_W-1:0]       source_x;
    logic [SRC_Y_W-1:0]       source_y;
    logic signed [POS_W-1:0]  dest_x;
    logic signed [POS_W-1:0]  dest_y;

    modport source (output valid, draw, source_x, source_y, dest_x, dest_y, input ready);
    modport sink   (input valid, draw, source_x, source_y, dest_x, dest_y, output ready);
endinterface

>>> sv/glyph_text_layout_core.sv
// Top level of the glyph text layout engine.
//
//   channel  dir  handshake         word
//   i_in     in   valid / ready     mode, code_point, start_x, start_y
//   o_out    out  valid / ready     draw, source_x, source_y, dest_x, dest_y
//   i_cfg    in   i_cfg_we          i_cfg_idx, i_cfg_data (no back-pressure)
//
// A glyph character passes from accept through divider load, the column/row divider at
// four bits a cycle, one multiply and one handoff before the next accept; other items go
// from accept straight to the handoff. A stalled output word holds the next result in the
// handoff step with i_in.ready low.
// After reset the glyph map is cleared with i_in.ready low.
module glyph_text_layout_core
    import glt_pkg::*;
#(
    parameter int CODE_SPACE  = 65536,
    parameter int GLYPH_LIMIT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    glt_in_if.sink                i_in,
    glt_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int GW         = $clog2(GLYPH_LIMIT);
    localparam int DIV_CYCLES = (GW + 3) / 4;

    t_cmd w_cmd;
    t_sts w_sts;

    glt_ctrl #(
        .DIV_CYCLES (DIV_CYCLES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    glt_dpath #(
        .CODE_SPACE  (CODE_SPACE),
        .GLYPH_LIMIT (GLYPH_LIMIT)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_in.mode),
        .i_code_point (i_in.code_point),
        .i_start_x    (i_in.start_x),
        .i_start_y    (i_in.start_y),
        .o_draw       (o_out.draw),
        .o_source_x   (o_out.source_x),
        .o_source_y   (o_out.source_y),
        .o_dest_x     (o_out.dest_x),
        .o_dest_y     (o_out.dest_y)
    );

    // A word without a tile carries all-zero coordinates.
    a_no_draw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.draw |->
            o_out.source_x == '0 && o_out.source_y == '0 &&
            o_out.dest_x == '0 && o_out.dest_y == '0)
        else $error("non-drawing word carries coordinates");

    // No item may enter while the glyph map is being cleared.
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_we |-> !i_in.ready)
        else $error("input accepted during map clear");

    // The output register is only reloaded when its word has gone.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_out.valid && !o_out.ready))
        else $error("output word overwritten while stalled");

endmodule

>>> sv/glt_ctrl.sv
// Sequencing state machine for the glyph text layout engine.
module glt_ctrl
    import glt_pkg::*;
#(
    parameter int DIV_CYCLES = 3
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CW = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_DIV   = 6'b001000,
        S_MUL   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_div_cnt, n_div_cnt;
    logic            r_out_valid, n_out_valid;
    logic            w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.glyph_item ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                o_cmd.div_load = 1'b1;
                n_div_cnt      = CW'(DIV_CYCLES - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == '0) begin
                    n_state = S_MUL;
                end else begin
                    n_div_cnt = r_div_cnt - 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> sv/glt_dpath.sv
// Datapath: glyph map memory, cursor, column/row divider and tile offsets.
module glt_dpath
    import glt_pkg::*;
#(
    parameter int CODE_SPACE  = 65536,
    parameter int GLYPH_LIMIT = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [CODE_W-1:0]        i_code_point,
    input  logic signed [POS_W-1:0]  i_start_x,
    input  logic signed [POS_W-1:0]  i_start_y,
    output logic                     o_draw,
    output logic [SRC_X_W-1:0]       o_source_x,
    output logic [SRC_Y_W-1:0]       o_source_y,
    output logic signed [POS_W-1:0]  o_dest_x,
    output logic signed [POS_W-1:0]  o_dest_y
);

    localparam int AW  = $clog2(CODE_SPACE);
    localparam int GW  = $clog2(GLYPH_LIMIT);
    localparam int DW  = ((GW + 3) / 4) * 4;
    localparam logic [CODE_W:0] CODE_LIMIT  = (CODE_W + 1)'(CODE_SPACE);
    localparam logic [GW:0]     GLYPH_COUNT = (GW + 1)'(GLYPH_LIMIT);

    // Configuration.
    logic [CFG_W-1:0] r_tile_w, r_tile_h, r_cols;
    logic [CFG_W-1:0] w_cols;

    // Table and cursor state.
    logic [GW:0]      r_next_glyph;
    logic [POS_W-1:0] r_cursor_x, r_cursor_y, r_line_x;
    logic [AW-1:0]    r_clr_addr;

    // Glyph map memory.
    logic [GW-1:0]    r_map [CODE_SPACE];
    logic [GW-1:0]    r_rd_glyph;
    logic             r_rd_ok;
    logic             w_mem_we;
    logic [AW-1:0]    w_mem_waddr;
    logic [GW-1:0]    w_mem_wdata;

    // Item decode.
    logic [CODE_W-1:0] w_fold;
    logic              w_fold_ok, w_code_ok, w_entry_we, w_glyph_item;
    logic [POS_W-1:0]  w_step_x;

    // Divider.
    logic [CFG_W-1:0]  r_rem, n_rem;
    logic [DW-1:0]     r_quo, n_quo;
    logic [CFG_W:0]    w_trial;

    // Result being built and the output word.
    logic [DW+CFG_W-1:0] w_prod_y;
    logic                r_res_draw;
    logic [SRC_X_W-1:0]  r_res_sx;
    logic [SRC_Y_W-1:0]  r_res_sy;
    logic [POS_W-1:0]    r_res_dx, r_res_dy;
    logic                r_out_draw;
    logic [SRC_X_W-1:0]  r_out_sx;
    logic [SRC_Y_W-1:0]  r_out_sy;
    logic [POS_W-1:0]    r_out_dx, r_out_dy;

    assign w_cols = (r_cols == '0) ? CFG_W'(1) : r_cols;

    always_comb begin
        if ((i_code_point >= LATIN_LO && i_code_point <= LATIN_HI) ||
            (i_code_point >= CYRIL_LO && i_code_point <= CYRIL_HI)) begin
            w_fold = i_code_point - FOLD_OFFSET;
        end else begin
            w_fold = i_code_point;
        end
    end

    assign w_fold_ok  = {1'b0, w_fold} < CODE_LIMIT;
    assign w_code_ok  = {1'b0, i_code_point} < CODE_LIMIT;
    assign w_entry_we = i_cmd.accept && (i_mode == MODE_ENTRY) &&
                        (i_code_point != CH_NEWLINE) && (i_code_point != CH_NONE) &&
                        w_code_ok && (r_next_glyph < GLYPH_COUNT);
    assign w_glyph_item = (i_mode == MODE_CHAR) && (i_code_point != CH_NUL) &&
                          (i_code_point != CH_NEWLINE) && (i_code_point != CH_SPACE) &&
                          (i_code_point != CH_TAB);
    assign w_step_x = r_cursor_x + {{(POS_W-CFG_W){1'b0}}, r_tile_w};

    assign o_sts.clr_last   = (r_clr_addr == AW'(CODE_SPACE - 1));
    assign o_sts.glyph_item = w_glyph_item;

    // The clearing pass owns the write port until it finishes.
    assign w_mem_we    = i_cmd.clr_we || w_entry_we;
    assign w_mem_waddr = i_cmd.clr_we ? r_clr_addr : i_code_point[AW-1:0];
    assign w_mem_wdata = i_cmd.clr_we ? '0 : r_next_glyph[GW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_map[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_glyph <= r_map[w_fold[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_ok <= w_fold_ok;
        end
    end

    // Restoring division, four quotient bits per cycle.
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        w_trial = '0;
        for (int k = 0; k < 4; k++) begin
            w_trial = {n_rem, n_quo[DW-1]};
            if (w_trial >= {1'b0, w_cols}) begin
                n_rem = CFG_W'(w_trial - {1'b0, w_cols});
                n_quo = {n_quo[DW-2:0], 1'b1};
            end else begin
                n_rem = w_trial[CFG_W-1:0];
                n_quo = {n_quo[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= r_rd_ok ? DW'(r_rd_glyph) : '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign w_prod_y = (DW + CFG_W)'(r_quo) * (DW + CFG_W)'(r_tile_h);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_draw <= w_glyph_item;
            r_res_sx   <= '0;
            r_res_sy   <= '0;
            r_res_dx   <= w_glyph_item ? w_step_x : '0;
            r_res_dy   <= w_glyph_item ? r_cursor_y : '0;
        end else if (i_cmd.mul) begin
            r_res_sx <= SRC_X_W'(r_rem) * SRC_X_W'(r_tile_w);
            r_res_sy <= SRC_Y_W'(w_prod_y);
        end
        if (i_cmd.out_load) begin
            r_out_draw <= r_res_draw;
            r_out_sx   <= r_res_sx;
            r_out_sy   <= r_res_sy;
            r_out_dx   <= r_res_dx;
            r_out_dy   <= r_res_dy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w     <= RST_TILE_WIDTH;
            r_tile_h     <= RST_TILE_HEIGHT;
            r_cols       <= RST_ATLAS_COLUMNS;
            r_next_glyph <= '0;
            r_cursor_x   <= '0;
            r_cursor_y   <= '0;
            r_line_x     <= '0;
            r_clr_addr   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TILE_WIDTH:    r_tile_w <= i_cfg_data;
                    REG_TILE_HEIGHT:   r_tile_h <= i_cfg_data;
                    REG_ATLAS_COLUMNS: r_cols   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_we) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_entry_we) begin
                r_next_glyph <= r_next_glyph + 1'b1;
            end
            if (i_cmd.accept) begin
                unique case (i_mode)
                    MODE_RESTART: r_next_glyph <= '0;
                    MODE_ENTRY: ;
                    MODE_BEGIN: begin
                        r_line_x   <= i_start_x - {{(POS_W-CFG_W){1'b0}}, r_tile_w};
                        r_cursor_x <= i_start_x - {{(POS_W-CFG_W){1'b0}}, r_tile_w};
                        r_cursor_y <= i_start_y;
                    end
                    MODE_CHAR: begin
                        case (i_code_point)
                            CH_NUL: ;
                            CH_NEWLINE: begin
                                r_cursor_y <= r_cursor_y +
                                              {{(POS_W-CFG_W){1'b0}}, r_tile_h};
                                r_cursor_x <= r_line_x;
                            end
                            CH_TAB: begin
                                r_cursor_x <= r_cursor_x +
                                              {{(POS_W-CFG_W-2){1'b0}}, r_tile_w, 2'b00};
                            end
                            default: r_cursor_x <= w_step_x;
                        endcase
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_draw     = r_out_draw;
    assign o_source_x = r_out_sx;
    assign o_source_y = r_out_sy;
    assign o_dest_x   = r_out_dx;
    assign o_dest_y   = r_out_dy;

endmodule

>>> tb/glyph_text_layout_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the glyph text layout core: directed and random text and table traffic.
module glyph_text_layout_core_tb;
    import glt_pkg::*;

    localparam int CODE_SPACE   = 65536;
    localparam int GLYPH_LIMIT  = 4096;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_ITEMS  = 112;
    localparam int TABLE_ITEMS  = 256;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CODE_W-1:0] code_point;
        logic [POS_W-1:0]  start_x;
        logic [POS_W-1:0]  start_y;
    } t_text_word;

    typedef struct packed {
        logic               draw;
        logic [SRC_X_W-1:0] source_x;
        logic [SRC_Y_W-1:0] source_y;
        logic [POS_W-1:0]   dest_x;
        logic [POS_W-1:0]   dest_y;
    } t_tile_copy;

    class layout_scoreboard;
        logic [CFG_W-1:0] tile_w;
        logic [CFG_W-1:0] tile_h;
        logic [CFG_W-1:0] columns;
        logic [11:0]      glyph_map [CODE_SPACE];
        logic [12:0]      next_glyph;
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        logic [POS_W-1:0] line_start_x;
        t_tile_copy       expected_copies [$];
        int               failures;

        function new();
            tile_w = RST_TILE_WIDTH;
            tile_h = RST_TILE_HEIGHT;
            columns = RST_ATLAS_COLUMNS;
            foreach (glyph_map[i]) glyph_map[i] = '0;
            next_glyph = '0;
            cursor_x = '0;
            cursor_y = '0;
            line_start_x = '0;
            failures = 0;
        endfunction

        function void set_config(logic [CFG_W-1:0] tw, logic [CFG_W-1:0] th,
                                 logic [CFG_W-1:0] cols);
            tile_w = tw;
            tile_h = th;
            columns = cols;
        endfunction

        function t_tile_copy lay_out_item(t_text_word w);
            t_tile_copy       copy;
            logic [CODE_W-1:0] code;
            int unsigned      glyph;
            int unsigned      cols;
            copy = '0;
            code = w.code_point;
            case (w.mode)
                MODE_RESTART: next_glyph = '0;
                MODE_ENTRY: begin
                    if (code != CH_NEWLINE && code != CH_NONE && next_glyph < GLYPH_LIMIT) begin
                        glyph_map[code] = next_glyph[11:0];
                        next_glyph = next_glyph + 1'b1;
                    end
                end
                MODE_BEGIN: begin
                    line_start_x = w.start_x - POS_W'(tile_w);
                    cursor_x = line_start_x;
                    cursor_y = w.start_y;
                end
                default: begin
                    if (code == CH_NEWLINE) begin
                        cursor_y = cursor_y + POS_W'(tile_h);
                        cursor_x = line_start_x;
                    end else if (code == CH_SPACE) begin
                        cursor_x = cursor_x + POS_W'(tile_w);
                    end else if (code == CH_TAB) begin
                        cursor_x = cursor_x + POS_W'(4 * tile_w);
                    end else if (code != CH_NUL) begin
                        if ((code >= LATIN_LO && code <= LATIN_HI) ||
                            (code >= CYRIL_LO && code <= CYRIL_HI)) begin
                            code = code - FOLD_OFFSET;
                        end
                        glyph = glyph_map[code];
                        // A column count of zero behaves as a single column.
                        cols = (columns == 0) ? 1 : columns;
                        cursor_x = cursor_x + POS_W'(tile_w);
                        copy.draw = 1'b1;
                        copy.source_x = SRC_X_W'((glyph % cols) * tile_w);
                        copy.source_y = SRC_Y_W'((glyph / cols) * tile_h);
                        copy.dest_x = cursor_x;
                        copy.dest_y = cursor_y;
                    end
                end
            endcase
            return copy;
        endfunction

        function void note_item(t_text_word w);
            expected_copies.push_back(lay_out_item(w));
        endfunction

        function void check_copy(t_tile_copy got);
            t_tile_copy want;
            if (expected_copies.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("tile copy with nothing expected: draw=%0b src=(%0d,%0d) dst=(%0d,%0d)",
                             got.draw, got.source_x, got.source_y,
                             $signed(got.dest_x), $signed(got.dest_y));
                end
                return;
            end
            want = expected_copies.pop_front();
            if (got.draw !== want.draw || got.source_x !== want.source_x ||
                got.source_y !== want.source_y || got.dest_x !== want.dest_x ||
                got.dest_y !== want.dest_y) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("tile copy mismatch at %0t: expected draw=%0b src=(%0d,%0d) dst=(%0d,%0d)",
                             $realtime, want.draw, want.source_x, want.source_y,
                             $signed(want.dest_x), $signed(want.dest_y));
                    $display("    actual draw=%0b src=(%0d,%0d) dst=(%0d,%0d)",
                             got.draw, got.source_x, got.source_y,
                             $signed(got.dest_x), $signed(got.dest_y));
                end
            end
        endfunction

        function void check_leftovers();
            if (expected_copies.size() != 0) begin
                failures++;
                $display("%0d tile copies never arrived", expected_copies.size());
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    int unsigned      src_idle_pct;
    int unsigned      sink_idle_pct;
    bit               rx_hold;
    int unsigned      cycles;
    logic [CODE_W-1:0] known_codes [$];
    layout_scoreboard scoreboard;

    glt_in_if  in_ch ();
    glt_out_if out_ch ();

    glyph_text_layout_core #(
        .CODE_SPACE  (CODE_SPACE),
        .GLYPH_LIMIT (GLYPH_LIMIT)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Receiver: random back-pressure, or a solid hold-off while rx_hold is set.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready <= !rx_hold && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk) begin : watch_output
        t_tile_copy got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.draw = out_ch.draw;
            got.source_x = out_ch.source_x;
            got.source_y = out_ch.source_y;
            got.dest_x = out_ch.dest_x;
            got.dest_y = out_ch.dest_y;
            scoreboard.check_copy(got);
        end
    end

    function automatic logic [CODE_W-1:0] any16();
        return CODE_W'($urandom);
    endfunction

    function automatic t_text_word word_of(logic [MODE_W-1:0] mode, logic [CODE_W-1:0] code,
                                           logic [POS_W-1:0] sx, logic [POS_W-1:0] sy);
        t_text_word w;
        w.mode = mode;
        w.code_point = code;
        w.start_x = sx;
        w.start_y = sy;
        return w;
    endfunction

    function automatic logic [CODE_W-1:0] pick_entry_code();
        int r;
        r = $urandom_range(99);
        if (r < 40) return CODE_W'($urandom_range(32, 127));
        if (r < 70) return CODE_W'($urandom_range(16'h0400, 16'h045F));
        if (r < 76) return CH_NEWLINE;
        if (r < 80) return CH_NONE;
        return any16();
    endfunction

    function automatic logic [CODE_W-1:0] pick_char();
        int r;
        logic [CODE_W-1:0] c;
        r = $urandom_range(99);
        if (r < 45 && known_codes.size() > 0) begin
            c = known_codes[$urandom_range(known_codes.size() - 1)];
            // Now and then ask for the lowercase form of a mapped capital.
            if ($urandom_range(1) == 1 &&
                ((c >= LATIN_LO - FOLD_OFFSET && c <= LATIN_HI - FOLD_OFFSET) ||
                 (c >= CYRIL_LO - FOLD_OFFSET && c <= CYRIL_HI - FOLD_OFFSET))) begin
                c = c + FOLD_OFFSET;
            end
        end else if (r < 55) begin
            c = CH_SPACE;
        end else if (r < 60) begin
            c = CH_TAB;
        end else if (r < 65) begin
            c = CH_NEWLINE;
        end else if (r < 68) begin
            c = CH_NUL;
        end else if (r < 80) begin
            c = CODE_W'($urandom_range(32, 127));
        end else if (r < 88) begin
            c = CODE_W'($urandom_range(16'h0400, 16'h045F));
        end else begin
            c = any16();
        end
        return c;
    endfunction

    task automatic send_word(t_text_word w);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= w.mode;
        in_ch.code_point <= w.code_point;
        in_ch.start_x <= w.start_x;
        in_ch.start_y <= w.start_y;
        do @(posedge clk); while (!in_ch.ready);
        scoreboard.note_item(w);
    endtask

    task automatic send_entry(logic [CODE_W-1:0] code);
        send_word(word_of(MODE_ENTRY, code, any16(), any16()));
        if (code != CH_NEWLINE && code != CH_NONE) begin
            known_codes.push_back(code);
            if (known_codes.size() > 64) void'(known_codes.pop_front());
        end
    endtask

    task automatic send_char(logic [CODE_W-1:0] code);
        send_word(word_of(MODE_CHAR, code, any16(), any16()));
    endtask

    task automatic send_begin(logic [POS_W-1:0] sx, logic [POS_W-1:0] sy);
        send_word(word_of(MODE_BEGIN, any16(), sx, sy));
    endtask

    // Stop offering words and wait until every tile copy is back.
    task automatic drain_copies();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (scoreboard.expected_copies.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic load_config(logic [CFG_W-1:0] tw, logic [CFG_W-1:0] th,
                               logic [CFG_W-1:0] cols);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= REG_TILE_WIDTH;
        cfg_data <= tw;
        @(negedge clk);
        cfg_idx <= REG_TILE_HEIGHT;
        cfg_data <= th;
        @(negedge clk);
        cfg_idx <= REG_ATLAS_COLUMNS;
        cfg_data <= cols;
        @(negedge clk);
        cfg_we <= 1'b0;
        scoreboard.set_config(tw, th, cols);
    endtask

    // Mostly well-formed text: table loads, a text origin, then runs of characters.
    task automatic run_text(int quota);
        int sent;
        int kind;
        int n;
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                if ($urandom_range(1) == 1) begin
                    send_word(word_of(MODE_RESTART, any16(), any16(), any16()));
                    sent++;
                end
                n = $urandom_range(1, 10);
                repeat (n) begin
                    send_entry(pick_entry_code());
                    sent++;
                end
            end else if (kind < 18) begin
                send_begin(any16(), any16());
                sent++;
            end else if (kind < 90) begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    send_char(pick_char());
                    sent++;
                end
            end else begin
                send_word(word_of(MODE_W'($urandom), any16(), any16(), any16()));
                sent++;
            end
        end
    endtask

    initial begin
        scoreboard = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_TILE_WIDTH;
        cfg_data = '0;
        rx_hold = 1'b0;
        src_idle_pct = 11;
        sink_idle_pct = 56;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_RESTART;
        in_ch.code_point = '0;
        in_ch.start_x = '0;
        in_ch.start_y = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_config(RST_TILE_WIDTH, RST_TILE_HEIGHT, RST_ATLAS_COLUMNS);

        // Directed: skipped table codes, case folding at the range edges,
        // cursor moves, unmapped codes and cursor wrap from the extremes.
        send_word(word_of(MODE_RESTART, '0, '0, '0));
        send_entry(LATIN_LO - FOLD_OFFSET);
        send_entry(CH_NEWLINE);
        send_entry(CH_NONE);
        send_entry(CYRIL_LO - FOLD_OFFSET);
        send_entry(LATIN_LO - FOLD_OFFSET + 16'd1);
        send_begin(16'h7FFF, 16'h8000);
        send_char(LATIN_LO);
        send_char(LATIN_HI);
        send_char(CYRIL_LO);
        send_char(CYRIL_HI);
        send_char(CH_NUL);
        send_char(CH_SPACE);
        send_char(CH_TAB);
        send_char(CH_NEWLINE);
        send_char(LATIN_LO - FOLD_OFFSET + 16'd1);
        send_char(CH_NONE);
        send_char(LATIN_LO - 16'd1);
        send_char(LATIN_HI + 16'd1);
        send_char(CYRIL_LO - 16'd1);
        send_char(CYRIL_HI + 16'd1);
        send_begin(16'h8000, 16'h7FFF);
        send_char(LATIN_LO - FOLD_OFFSET);
        send_char(CH_NEWLINE);
        send_char(CYRIL_LO - FOLD_OFFSET);
        drain_copies();

        // Load a long table so that glyph numbers of several quotient digits
        // reach the divider.
        send_word(word_of(MODE_RESTART, '0, '0, '0));
        for (int i = 0; i < TABLE_ITEMS; i++) send_entry(CODE_W'(i));
        drain_copies();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_config(8'd255, 8'd255, 8'd255);
                1: load_config(8'd0, 8'd0, 8'd0);
                2: load_config(8'd1, 8'd1, 8'd1);
                5: load_config(RST_TILE_WIDTH, RST_TILE_HEIGHT, RST_ATLAS_COLUMNS);
                default: load_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
            endcase
            case (phase / 2)
                0: begin
                    src_idle_pct = 11;
                    sink_idle_pct = 56;
                end
                1: begin
                    src_idle_pct = 56;
                    sink_idle_pct = 11;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            if (phase == 1) begin
                // Hold the output long enough for the input side to back up.
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (300) @(posedge clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            if (phase == 3) begin
                run_text(PHASE_ITEMS / 2);
                drain_copies();
                run_text(PHASE_ITEMS / 2);
            end else begin
                run_text(PHASE_ITEMS);
            end
            drain_copies();
        end

        scoreboard.check_leftovers();
        if (scoreboard.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
